[rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg - rational arithmetic unit shared definitions
// widths, operation codes and small helpers for sign/magnitude handling
// ----------------------------------------------------------------------------
package rau_pkg;

    // operand field width, range 4 to 32
    localparam int OPERAND_WIDTH = 16;
    // exact magnitude of a cross-product sum
    localparam int MAG_W = 2 * OPERAND_WIDTH + 1;
    // result field width
    localparam int OUT_W = 33;
    // working width for the final two's complement encode
    localparam int EXT_W = (MAG_W > OUT_W) ? MAG_W : OUT_W;
    // shift counter width of the remainder unit
    localparam int CNT_W = $clog2(MAG_W);
    localparam int OPC_W = 2;

    localparam logic [OPC_W-1:0] OP_ADD = 2'd0;
    localparam logic [OPC_W-1:0] OP_SUB = 2'd1;
    localparam logic [OPC_W-1:0] OP_MUL = 2'd2;
    localparam logic [OPC_W-1:0] OP_DIV = 2'd3;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

    // magnitude of a two's complement operand field
    function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
        return v[OPERAND_WIDTH-1] ? (~v + OPERAND_WIDTH'(1)) : v;
    endfunction

    // sign/magnitude to two's complement result field, wrapped
    function automatic logic [OUT_W-1:0] enc_out(input logic neg, input logic [MAG_W-1:0] mag);
        logic [EXT_W-1:0] e;
        e = EXT_W'(mag);
        if (neg) begin
            e = ~e + EXT_W'(1);
        end
        return e[OUT_W-1:0];
    endfunction

endpackage

[rtl/rational_arith_unit.sv]
// ----------------------------------------------------------------------------
// rational_arith_unit - fraction arithmetic with gcd reduction
// cross-multiplies two fractions and reduces the result by Euclid's gcd
// ----------------------------------------------------------------------------
// usage
//   input channel (s_*): one transaction carries an opcode (add, subtract,
//   multiply, divide) and two fractions a_num/a_den and b_num/b_den
//   output channel (m_*): one transaction per input, the reduced numerator
//   and denominator and a status bit (divide by a zero fraction gives 0/1
//   with status set)
// sequencing
//   one transaction is worked on at a time; s_ready is high only while idle
//   three products on the shared multiplier, then a combine step, then the
//   Euclid loop on a shared shift/subtract remainder unit (each step aligns
//   the divisor, then subtracts one quotient bit at a time), then two
//   quotients on the same unit; the time to the result is set by the
//   number of Euclid steps and quotient bits
//   a divide by a zero fraction goes straight to the done state
// reset
//   aresetn is synchronous, active low; it returns the sequencer to idle
//   and drops m_valid
// back-pressure
//   the result sits in an output register; the block is ready for the next
//   transaction while it waits, and a later result waits in the done state
//   until the register is free
// ----------------------------------------------------------------------------
module rational_arith_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [rau_pkg::OPC_W-1:0]             s_opcode,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_a_num,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_a_den,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_b_num,
    input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] s_b_den,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rau_pkg::OUT_W-1:0]      m_result_num,
    output logic signed [rau_pkg::OUT_W-1:0]      m_result_den,
    output logic                                  m_status
);
    import rau_pkg::*;

    localparam int W = OPERAND_WIDTH;
    localparam int P_W = 2 * OPERAND_WIDTH;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL0   = 4'd1;
    localparam logic [3:0] ST_MUL1   = 4'd2;
    localparam logic [3:0] ST_MUL2   = 4'd3;
    localparam logic [3:0] ST_SUM    = 4'd4;
    localparam logic [3:0] ST_CHK    = 4'd5;
    localparam logic [3:0] ST_DSHIFT = 4'd6;
    localparam logic [3:0] ST_DSUB   = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    // what the remainder unit is currently doing
    localparam logic [1:0] PH_EUCLID = 2'd0;
    localparam logic [1:0] PH_QNUM   = 2'd1;
    localparam logic [1:0] PH_QDEN   = 2'd2;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [OPC_W-1:0] opc_reg, opc_next;

    // operands in sign/magnitude form
    logic             an_neg_reg, an_neg_next, ad_neg_reg, ad_neg_next;
    logic             bn_neg_reg, bn_neg_next, bd_neg_reg, bd_neg_next;
    logic [W-1:0]     an_mag_reg, an_mag_next, ad_mag_reg, ad_mag_next;
    logic [W-1:0]     bn_mag_reg, bn_mag_next, bd_mag_reg, bd_mag_next;

    // registered products
    logic [P_W-1:0]   p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic             p0_neg_reg, p0_neg_next, p1_neg_reg, p1_neg_next;
    logic             p2_neg_reg, p2_neg_next;

    // unreduced result
    logic [MAG_W-1:0] num_mag_reg, num_mag_next, den_mag_reg, den_mag_next;
    logic             num_neg_reg, num_neg_next, den_neg_reg, den_neg_next;

    // euclid pair, step parity and gcd sign
    logic [MAG_W-1:0] x_reg, x_next, y_reg, y_next;
    logic             par_reg, par_next;
    logic             gneg_reg, gneg_next;

    // shared remainder unit
    logic [MAG_W-1:0] r_reg, r_next, d_reg, d_next, q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // reduced magnitudes and status waiting for the output register
    logic [MAG_W-1:0] qn_reg, qn_next, qd_reg, qd_next;
    logic             status_reg, status_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_num_reg, m_num_next, m_den_reg, m_den_next;
    logic             m_status_reg, m_status_next;

    // shared multiplier
    logic [W-1:0]     mul_x, mul_y;
    logic             mul_xneg, mul_yneg;
    logic [P_W-1:0]   mul_p;
    logic             mul_neg;

    // product combine
    logic [MAG_W-1:0] sa_mag, sb_mag, sum_mag;
    logic             sb_neg, sum_neg;

    // remainder unit step
    logic [MAG_W:0]   d_dbl;
    logic             div_ge;
    logic [MAG_W-1:0] r_sub, q_sh;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_result_num = m_num_reg;
    assign m_result_den = m_den_reg;
    assign m_status     = m_status_reg;

    // operand select for the shared multiplier
    always_comb begin
        case (state_reg)
            ST_MUL0: begin
                mul_x    = an_mag_reg;
                mul_xneg = an_neg_reg;
                mul_y    = (opc_reg == OP_MUL) ? bn_mag_reg : bd_mag_reg;
                mul_yneg = (opc_reg == OP_MUL) ? bn_neg_reg : bd_neg_reg;
            end
            ST_MUL1: begin
                mul_x    = ad_mag_reg;
                mul_xneg = ad_neg_reg;
                mul_y    = bn_mag_reg;
                mul_yneg = bn_neg_reg;
            end
            default: begin
                mul_x    = ad_mag_reg;
                mul_xneg = ad_neg_reg;
                mul_y    = bd_mag_reg;
                mul_yneg = bd_neg_reg;
            end
        endcase
    end

    assign mul_p   = P_W'(mul_x) * P_W'(mul_y);
    // a zero product carries no sign
    assign mul_neg = (mul_xneg ^ mul_yneg) && (mul_p != '0);

    // signed-magnitude add of the two cross products
    always_comb begin
        sa_mag = MAG_W'(p0_reg);
        sb_mag = MAG_W'(p1_reg);
        sb_neg = (opc_reg == OP_SUB) ? (!p1_neg_reg && (p1_reg != '0)) : p1_neg_reg;
        if (p0_neg_reg == sb_neg) begin
            sum_mag = sa_mag + sb_mag;
            sum_neg = p0_neg_reg;
        end else if (sa_mag >= sb_mag) begin
            sum_mag = sa_mag - sb_mag;
            sum_neg = p0_neg_reg;
        end else begin
            sum_mag = sb_mag - sa_mag;
            sum_neg = sb_neg;
        end
        if (sum_mag == '0) begin
            sum_neg = 1'b0;
        end
    end

    // one shift/subtract step of the remainder unit
    assign d_dbl  = {d_reg, 1'b0};
    assign div_ge = (r_reg >= d_reg);
    assign r_sub  = div_ge ? (r_reg - d_reg) : r_reg;
    assign q_sh   = {q_reg[MAG_W-2:0], div_ge};

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        opc_next      = opc_reg;
        an_neg_next   = an_neg_reg;
        ad_neg_next   = ad_neg_reg;
        bn_neg_next   = bn_neg_reg;
        bd_neg_next   = bd_neg_reg;
        an_mag_next   = an_mag_reg;
        ad_mag_next   = ad_mag_reg;
        bn_mag_next   = bn_mag_reg;
        bd_mag_next   = bd_mag_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        p0_neg_next   = p0_neg_reg;
        p1_neg_next   = p1_neg_reg;
        p2_neg_next   = p2_neg_reg;
        num_mag_next  = num_mag_reg;
        den_mag_next  = den_mag_reg;
        num_neg_next  = num_neg_reg;
        den_neg_next  = den_neg_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        par_next      = par_reg;
        gneg_next     = gneg_reg;
        r_next        = r_reg;
        d_next        = d_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        qn_next       = qn_reg;
        qd_next       = qd_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_num_next    = m_num_reg;
        m_den_next    = m_den_reg;
        m_status_next = m_status_reg;

        // output register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    opc_next    = s_opcode;
                    an_neg_next = s_a_num[W-1];
                    ad_neg_next = s_a_den[W-1];
                    bn_neg_next = s_b_num[W-1];
                    bd_neg_next = s_b_den[W-1];
                    an_mag_next = mag_of(s_a_num);
                    ad_mag_next = mag_of(s_a_den);
                    bn_mag_next = mag_of(s_b_num);
                    bd_mag_next = mag_of(s_b_den);
                    if ((s_opcode == OP_DIV) && (s_b_num == '0)) begin
                        // divide by a zero fraction: 0/1 with status
                        qn_next      = '0;
                        qd_next      = MAG_W'(1);
                        num_neg_next = 1'b0;
                        den_neg_next = 1'b0;
                        gneg_next    = 1'b0;
                        status_next  = STATUS_DIV_ZERO;
                        state_next   = ST_DONE;
                    end else begin
                        status_next = STATUS_OK;
                        state_next  = ST_MUL0;
                    end
                end
            end
            ST_MUL0: begin
                p0_next     = mul_p;
                p0_neg_next = mul_neg;
                state_next  = ST_MUL1;
            end
            ST_MUL1: begin
                p1_next     = mul_p;
                p1_neg_next = mul_neg;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                p2_next     = mul_p;
                p2_neg_next = mul_neg;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                if ((opc_reg == OP_ADD) || (opc_reg == OP_SUB)) begin
                    num_mag_next = sum_mag;
                    num_neg_next = sum_neg;
                end else begin
                    num_mag_next = MAG_W'(p0_reg);
                    num_neg_next = p0_neg_reg;
                end
                if (opc_reg == OP_DIV) begin
                    den_mag_next = MAG_W'(p1_reg);
                    den_neg_next = p1_neg_reg;
                end else begin
                    den_mag_next = MAG_W'(p2_reg);
                    den_neg_next = p2_neg_reg;
                end
                x_next     = num_mag_next;
                y_next     = den_mag_next;
                par_next   = 1'b0;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (y_reg == '0) begin
                    if (x_reg == '0) begin
                        // zero gcd: pass the pair through unreduced
                        qn_next    = num_mag_reg;
                        qd_next    = den_mag_reg;
                        gneg_next  = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        gneg_next  = par_reg ? den_neg_reg : num_neg_reg;
                        r_next     = num_mag_reg;
                        d_next     = x_reg;
                        q_next     = '0;
                        cnt_next   = '0;
                        phase_next = PH_QNUM;
                        state_next = ST_DSHIFT;
                    end
                end else begin
                    r_next     = x_reg;
                    d_next     = y_reg;
                    q_next     = '0;
                    cnt_next   = '0;
                    phase_next = PH_EUCLID;
                    state_next = ST_DSHIFT;
                end
            end
            ST_DSHIFT: begin
                // align the divisor under the dividend's top bit
                if (d_dbl <= {1'b0, r_reg}) begin
                    d_next   = d_dbl[MAG_W-1:0];
                    cnt_next = cnt_reg + CNT_W'(1);
                end else begin
                    state_next = ST_DSUB;
                end
            end
            ST_DSUB: begin
                r_next = r_sub;
                q_next = q_sh;
                if (cnt_reg == '0) begin
                    case (phase_reg)
                        PH_EUCLID: begin
                            x_next     = y_reg;
                            y_next     = r_sub;
                            par_next   = !par_reg;
                            state_next = ST_CHK;
                        end
                        PH_QNUM: begin
                            qn_next    = q_sh;
                            r_next     = den_mag_reg;
                            d_next     = x_reg;
                            q_next     = '0;
                            phase_next = PH_QDEN;
                            state_next = ST_DSHIFT;
                        end
                        default: begin
                            qd_next    = q_sh;
                            state_next = ST_DONE;
                        end
                    endcase
                end else begin
                    d_next   = {1'b0, d_reg[MAG_W-1:1]};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_DONE: begin
                // wait for the output register to be free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_num_next    = enc_out(num_neg_reg ^ gneg_reg, qn_reg);
                    m_den_next    = enc_out(den_neg_reg ^ gneg_reg, qd_reg);
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg    <= phase_next;
        opc_reg      <= opc_next;
        an_neg_reg   <= an_neg_next;
        ad_neg_reg   <= ad_neg_next;
        bn_neg_reg   <= bn_neg_next;
        bd_neg_reg   <= bd_neg_next;
        an_mag_reg   <= an_mag_next;
        ad_mag_reg   <= ad_mag_next;
        bn_mag_reg   <= bn_mag_next;
        bd_mag_reg   <= bd_mag_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        p0_neg_reg   <= p0_neg_next;
        p1_neg_reg   <= p1_neg_next;
        p2_neg_reg   <= p2_neg_next;
        num_mag_reg  <= num_mag_next;
        den_mag_reg  <= den_mag_next;
        num_neg_reg  <= num_neg_next;
        den_neg_reg  <= den_neg_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        par_reg      <= par_next;
        gneg_reg     <= gneg_next;
        r_reg        <= r_next;
        d_reg        <= d_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        qn_reg       <= qn_next;
        qd_reg       <= qd_next;
        status_reg   <= status_next;
        m_num_reg    <= m_num_next;
        m_den_reg    <= m_den_next;
        m_status_reg <= m_status_next;
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for rational_arith_unit
// drives fraction pairs with every opcode through the valid/ready input
// channel, predicts the reduced quotient of each transaction and compares
// every output transaction field by field, in order, under random idling
// ----------------------------------------------------------------------------
module tb;
    import rau_pkg::*;

    localparam int      W            = OPERAND_WIDTH;
    localparam logic signed [W-1:0] OPND_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] OPND_MIN = {1'b1, {(W - 1){1'b0}}};
    localparam int      RANDOM_ITEMS = 400;
    // generous bound covering the slowest items plus both idle gaps
    localparam int      CYCLE_LIMIT  = 1000000;
    localparam int      DRAIN_CYCLES = 450;

    typedef struct {
        logic signed [OUT_W-1:0] num;
        logic signed [OUT_W-1:0] den;
        logic                    status;
    } fraction_result_t;

    // sign and magnitude, the form the block works in
    typedef struct {
        bit          neg;
        logic [63:0] mag;
    } sign_mag_t;

    // ------------------------------------------------------------------------
    // scoreboard: reduced fraction expected for each accepted transaction
    // ------------------------------------------------------------------------
    class fraction_scoreboard;
        fraction_result_t expected_q[$];
        int unsigned      mismatches;

        static function sign_mag_t make_sm(bit neg, logic [63:0] mag);
            sign_mag_t r;
            r.mag = mag;
            r.neg = (mag != 0) ? neg : 1'b0;
            return r;
        endfunction

        static function sign_mag_t field_sm(logic signed [W-1:0] v);
            logic [W-1:0] m;
            m = v[W-1] ? (~v + 1'b1) : v;
            return make_sm(v[W-1], 64'(m));
        endfunction

        static function sign_mag_t mul_sm(sign_mag_t x, sign_mag_t y);
            return make_sm(x.neg != y.neg, x.mag * y.mag);
        endfunction

        static function sign_mag_t add_sm(sign_mag_t x, sign_mag_t y);
            if (x.neg == y.neg) begin
                return make_sm(x.neg, x.mag + y.mag);
            end
            if (x.mag >= y.mag) begin
                return make_sm(x.neg, x.mag - y.mag);
            end
            return make_sm(y.neg, y.mag - x.mag);
        endfunction

        static function logic [OUT_W-1:0] to_twos(sign_mag_t x);
            logic [OUT_W-1:0] e;
            e = x.mag[OUT_W-1:0];
            if (x.neg) begin
                e = ~e + 1'b1;
            end
            return e;
        endfunction

        // cross-multiply, then divide both parts by the truncating-remainder gcd
        static function fraction_result_t predict_reduced(
            logic [OPC_W-1:0] op, logic signed [W-1:0] an, logic signed [W-1:0] ad,
            logic signed [W-1:0] bn, logic signed [W-1:0] bd);
            fraction_result_t res;
            sign_mag_t        num, den, g, rn, rd, san, sad, sbn, sbd;
            logic [63:0]      x, y, t;
            bit               odd_steps;
            san = field_sm(an);
            sad = field_sm(ad);
            sbn = field_sm(bn);
            sbd = field_sm(bd);
            case (op)
                OP_ADD: begin
                    num = add_sm(mul_sm(san, sbd), mul_sm(sad, sbn));
                    den = mul_sm(sad, sbd);
                end
                OP_SUB: begin
                    num = mul_sm(sad, sbn);
                    num = add_sm(mul_sm(san, sbd), make_sm(!num.neg, num.mag));
                    den = mul_sm(sad, sbd);
                end
                OP_MUL: begin
                    num = mul_sm(san, sbn);
                    den = mul_sm(sad, sbd);
                end
                default: begin
                    if (sbn.mag == 0) begin
                        res.num    = 0;
                        res.den    = 1;
                        res.status = STATUS_DIV_ZERO;
                        return res;
                    end
                    num = mul_sm(san, sbd);
                    den = mul_sm(sad, sbn);
                end
            endcase
            x = num.mag;
            y = den.mag;
            odd_steps = 1'b0;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
                odd_steps = !odd_steps;
            end
            // gcd sign follows the parity of the loop
            g = make_sm(odd_steps ? den.neg : num.neg, x);
            if (g.mag == 0) begin
                rn = num;
                rd = den;
            end else begin
                rn = make_sm(num.neg != g.neg, num.mag / g.mag);
                rd = make_sm(den.neg != g.neg, den.mag / g.mag);
            end
            res.num    = to_twos(rn);
            res.den    = to_twos(rd);
            res.status = STATUS_OK;
            return res;
        endfunction

        function void note_operands(logic [OPC_W-1:0] op, logic signed [W-1:0] an,
            logic signed [W-1:0] ad, logic signed [W-1:0] bn, logic signed [W-1:0] bd);
            expected_q.push_back(predict_reduced(op, an, ad, bn, bd));
        endfunction

        function void check_result(logic signed [OUT_W-1:0] num,
            logic signed [OUT_W-1:0] den, logic status);
            fraction_result_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d/%0d status %0d",
                         $time, num, den, status);
                mismatches++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (num !== exp_r.num) begin
                $display("%0t: result_num expected %0d, actual %0d", $time, exp_r.num, num);
                mismatches++;
            end
            if (den !== exp_r.den) begin
                $display("%0t: result_den expected %0d, actual %0d", $time, exp_r.den, den);
                mismatches++;
            end
            if (status !== exp_r.status) begin
                $display("%0t: status expected %0d, actual %0d", $time, exp_r.status, status);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [OPC_W-1:0]        s_opcode;
    logic signed [W-1:0]     s_a_num;
    logic signed [W-1:0]     s_a_den;
    logic signed [W-1:0]     s_b_num;
    logic signed [W-1:0]     s_b_den;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [OUT_W-1:0] m_result_num;
    logic signed [OUT_W-1:0] m_result_den;
    logic                    m_status;

    fraction_scoreboard sb = new();
    int unsigned        cycle_count;
    // when set the side concerned runs back to back with no idling
    bit                 steady_in;
    bit                 steady_out;

    rational_arith_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_a_num      (s_a_num),
        .s_a_den      (s_a_den),
        .s_b_num      (s_b_num),
        .s_b_den      (s_b_den),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result_num (m_result_num),
        .m_result_den (m_result_den),
        .m_status     (m_status)
    );

    always #10 aclk = ~aclk;

    // known values on every input from time zero
    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_opcode    = OP_ADD;
        s_a_num     = '0;
        s_a_den     = '0;
        s_b_num     = '0;
        s_b_den     = '0;
        m_ready     = 1'b0;
        cycle_count = 0;
        steady_in   = 1'b0;
        steady_out  = 1'b0;
    end

    // watchdog: generous bound on the whole run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // monitor: values sampled at the edge, before the block updates
    // output check first, a result can never belong to the transaction
    // accepted at the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_result(m_result_num, m_result_den, m_status);
            end
            if (s_valid && s_ready) begin
                sb.note_operands(s_opcode, s_a_num, s_a_den, s_b_num, s_b_den);
            end
        end
    end

    // result side: random stall before each transaction, none when steady
    initial begin
        int unsigned stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = steady_out ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // one input transaction: optional gap, then hold valid until accepted
    // valid is only lowered when a gap follows, never dropped and raised
    // again within one edge
    task automatic send_item(logic [OPC_W-1:0] op, logic signed [W-1:0] an,
        logic signed [W-1:0] ad, logic signed [W-1:0] bn, logic signed [W-1:0] bd);
        int unsigned gap;
        gap = steady_in ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_a_num  <= an;
        s_a_den  <= ad;
        s_b_num  <= bn;
        s_b_den  <= bd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // operand draw: full range, small values, or small values scaled by a
    // shared factor so that reduction has real work to do
    function automatic logic signed [W-1:0] draw_operand(int unsigned kind, int factor);
        case (kind)
            0:       return W'($urandom);
            1:       return W'(int'($urandom_range(0, 48)) - 24);
            default: return W'(factor * (int'($urandom_range(0, 40)) - 20));
        endcase
    endfunction

    task automatic send_random_item();
        logic [OPC_W-1:0]    op;
        logic signed [W-1:0] an, ad, bn, bd;
        int unsigned         kind;
        int                  factor;
        op     = OPC_W'($urandom_range(0, 3));
        kind   = $urandom_range(0, 2);
        factor = $urandom_range(1, 60);
        an = draw_operand(kind, factor);
        ad = draw_operand(kind, factor);
        bn = draw_operand(kind, factor);
        bd = draw_operand(kind, factor);
        // zero denominators kept rare, they reduce to a bare sign over zero
        if (ad == 0 && $urandom_range(0, 3) != 0) ad = 1;
        if (bd == 0 && $urandom_range(0, 3) != 0) bd = -1;
        if ($urandom_range(0, 39) == 0) ad = 0;
        if ($urandom_range(0, 39) == 0) bd = 0;
        // divide by a zero fraction
        if (op == OP_DIV && $urandom_range(0, 15) == 0) bn = 0;
        send_item(op, an, ad, bn, bd);
    endtask

    // hold the input side until every outstanding result has arrived
    task automatic wait_for_drain();
        // let the monitor note a transaction accepted at this edge first
        @(negedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: sums, differences, products and quotients, sign handling
        send_item(OP_ADD, 1, 2, 1, 3);
        send_item(OP_SUB, 1, 2, 1, 2);
        send_item(OP_ADD, 1, -2, 1, -3);
        send_item(OP_SUB, 7, -9, 2, 5);
        send_item(OP_MUL, 12, 18, 15, -20);
        send_item(OP_DIV, -6, 4, 9, -8);
        send_item(OP_MUL, -1, -1, -1, -1);
        send_item(OP_ADD, 0, 1, 0, 1);
        // field extremes, largest cross products
        send_item(OP_MUL, OPND_MAX, OPND_MIN, OPND_MAX, OPND_MIN);
        send_item(OP_DIV, OPND_MIN, OPND_MIN, OPND_MIN, OPND_MAX);
        send_item(OP_ADD, OPND_MIN, OPND_MIN, OPND_MIN, OPND_MIN);
        send_item(OP_ADD, OPND_MIN, OPND_MAX, OPND_MIN, OPND_MAX);
        send_item(OP_SUB, OPND_MIN, 1, OPND_MAX, 1);
        send_item(OP_SUB, OPND_MIN, OPND_MAX, OPND_MAX, OPND_MIN);
        send_item(OP_DIV, OPND_MAX, 1, 1, OPND_MAX);
        send_item(OP_DIV, 0, 5, -3, 7);
        // divide by a zero fraction, also with a zero denominator
        send_item(OP_DIV, 5, 7, 0, 3);
        send_item(OP_DIV, OPND_MIN, 0, 0, 0);
        // zero over zero left unreduced
        send_item(OP_MUL, 0, 0, 3, 4);
        send_item(OP_ADD, 1, 0, 1, 0);
        // nonzero over zero reduces to a sign over zero
        send_item(OP_MUL, 3, 0, 5, 7);
        send_item(OP_MUL, -3, 0, 5, 7);
        send_item(OP_SUB, 4, -6, 1, 0);
        s_valid <= 1'b0;
        wait_for_drain();
        @(posedge aclk);

        // random part, idling switched off for some stretches
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) begin
                steady_in  = ($urandom_range(0, 3) == 0);
                steady_out = ($urandom_range(0, 3) == 0);
            end
            if (i == RANDOM_ITEMS / 2) begin
                s_valid <= 1'b0;
                wait_for_drain();
                @(posedge aclk);
            end
            send_random_item();
        end
        s_valid <= 1'b0;

        wait_for_drain();
        // any stray extra transaction shows up as an unexpected result
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
